[hw/rtl/skt_pkg.sv]
package skt_pkg;

   localparam int KEY_W = 32;
   localparam int PAY_W = 32;
   localparam int FUNC_W = 2;
   localparam int STATUS_W = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_FIND   = 2'd1,
      FUNC_DELETE = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DUP      = 2'd1,
      STATUS_NOTFOUND = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CMP,
      S_COMMIT
   } state_type;

   typedef struct packed {
      logic cmp;
      logic ins;
      logic del;
   } ctrl_type;

endpackage

[hw/rtl/skt_if.sv]
interface skt_req_if;
   logic                                 valid;
   logic                                 ready;
   logic        [skt_pkg::FUNC_W-1:0]    func;
   logic signed [skt_pkg::KEY_W-1:0]     key;
   logic        [skt_pkg::PAY_W-1:0]     payload;

   modport source (output valid, func, key, payload, input ready);
   modport sink (input valid, func, key, payload, output ready);
endinterface

interface skt_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic        [skt_pkg::STATUS_W-1:0]  status;
   logic        [skt_pkg::PAY_W-1:0]     found_payload;

   modport source (output valid, status, found_payload, input ready);
   modport sink (input valid, status, found_payload, output ready);
endinterface

[hw/rtl/skt_cell.sv]
module skt_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  skt_pkg::ctrl_type                 ctrl,
   input  logic signed [skt_pkg::KEY_W-1:0]  new_key,
   input  logic        [skt_pkg::PAY_W-1:0]  new_payload,
   input  logic signed [skt_pkg::KEY_W-1:0]  prev_key,
   input  logic        [skt_pkg::PAY_W-1:0]  prev_payload,
   input  logic                              prev_valid,
   input  logic                              prev_lt,
   input  logic signed [skt_pkg::KEY_W-1:0]  next_key,
   input  logic        [skt_pkg::PAY_W-1:0]  next_payload,
   input  logic                              next_valid,
   output logic signed [skt_pkg::KEY_W-1:0]  key,
   output logic        [skt_pkg::PAY_W-1:0]  payload,
   output logic                              valid,
   output logic                              lt,
   output logic                              eq,
   output logic        [skt_pkg::PAY_W-1:0]  hit_payload
);

   logic signed [skt_pkg::KEY_W-1:0] key_ff, key_in;
   logic        [skt_pkg::PAY_W-1:0] payload_ff, payload_in;
   logic                             valid_ff, valid_in;
   logic                             lt_ff, eq_ff;

   always_comb begin
      key_in = key_ff;
      payload_in = payload_ff;
      valid_in = valid_ff;
      if (ctrl.ins && !lt_ff) begin
         if (prev_lt) begin
            key_in = new_key;
            payload_in = new_payload;
            valid_in = 1'b1;
         end else begin
            key_in = prev_key;
            payload_in = prev_payload;
            valid_in = prev_valid;
         end
      end else if (ctrl.del && !lt_ff) begin
         key_in = next_key;
         payload_in = next_payload;
         valid_in = next_valid;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      payload_ff <= payload_in;
      if (reset) begin
         valid_ff <= 1'b0;
         lt_ff <= 1'b0;
         eq_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ctrl.cmp) begin
            lt_ff <= valid_ff && (key_ff < new_key);
            eq_ff <= valid_ff && (key_ff == new_key);
         end
      end
   end

   assign key = key_ff;
   assign payload = payload_ff;
   assign valid = valid_ff;
   assign lt = lt_ff;
   assign eq = eq_ff;
   assign hit_payload = eq_ff ? payload_ff : '0;

endmodule

[hw/rtl/sorted_key_table.sv]
// A taken request passes a compare state across the cell chain and then a commit
// state that shifts the chain for an insert or delete and registers the result into
// the response slot. The next request is taken only while idle or in that commit state.
// A stalled response holds the commit cycle until the response slot frees.
// Reset (synchronous) empties the table and drops any pending response.
module sorted_key_table #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   skt_req_if.sink     req_chan,
   skt_rsp_if.source   rsp_chan
);

   skt_pkg::state_type state_ff, state_in;
   skt_pkg::ctrl_type  ctrl;

   logic [skt_pkg::FUNC_W-1:0]       op_func_ff;
   logic signed [skt_pkg::KEY_W-1:0] op_key_ff;
   logic [skt_pkg::PAY_W-1:0]        op_payload_ff;

   logic                             rsp_valid_ff;
   logic [skt_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [skt_pkg::PAY_W-1:0]        rsp_found_ff, rsp_found_in;

   logic signed [skt_pkg::KEY_W-1:0] key_arr [DEPTH];
   logic [skt_pkg::PAY_W-1:0]        payload_arr [DEPTH];
   logic [skt_pkg::PAY_W-1:0]        hit_arr [DEPTH];
   logic [DEPTH-1:0]                 valid_vec, lt_vec, eq_vec;

   logic req_take, out_free, advance, hit, full;
   logic is_insert, is_find, is_delete;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_take = req_chan.valid && req_chan.ready;
   assign hit = |eq_vec;
   assign full = valid_vec[DEPTH-1];
   assign is_insert = op_func_ff == skt_pkg::FUNC_INSERT;
   assign is_find = op_func_ff == skt_pkg::FUNC_FIND;
   assign is_delete = op_func_ff == skt_pkg::FUNC_DELETE;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         skt_pkg::S_IDLE: begin
            if (req_chan.valid) state_in = skt_pkg::S_CMP;
         end
         skt_pkg::S_CMP: begin
            state_in = skt_pkg::S_COMMIT;
         end
         skt_pkg::S_COMMIT: begin
            if (out_free) state_in = req_chan.valid ? skt_pkg::S_CMP : skt_pkg::S_IDLE;
         end
         default: state_in = skt_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = 1'b0;
      advance = 1'b0;
      ctrl = '0;
      case (state_ff)
         skt_pkg::S_IDLE: begin
            req_chan.ready = 1'b1;
         end
         skt_pkg::S_CMP: begin
            ctrl.cmp = 1'b1;
         end
         skt_pkg::S_COMMIT: begin
            advance = out_free;
            req_chan.ready = out_free;
            ctrl.ins = out_free && is_insert && !hit && !full;
            ctrl.del = out_free && is_delete && hit;
         end
         default: begin
            req_chan.ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_status_in = skt_pkg::STATUS_NOTFOUND;
      rsp_found_in = '0;
      if (is_insert) begin
         if (hit) rsp_status_in = skt_pkg::STATUS_DUP;
         else if (full) rsp_status_in = skt_pkg::STATUS_FULL;
         else rsp_status_in = skt_pkg::STATUS_OK;
      end else if ((is_find || is_delete) && hit) begin
         rsp_status_in = skt_pkg::STATUS_OK;
      end
      if (is_find) begin
         for (int i = 0; i < DEPTH; i++) rsp_found_in = rsp_found_in | hit_arr[i];
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_func_ff <= req_chan.func;
         op_key_ff <= req_chan.key;
         op_payload_ff <= req_chan.payload;
      end
      if (advance) begin
         rsp_status_ff <= rsp_status_in;
         rsp_found_ff <= rsp_found_in;
      end
      if (reset) begin
         state_ff <= skt_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (advance) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.found_payload = rsp_found_ff;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [skt_pkg::KEY_W-1:0] p_key, n_key;
      logic [skt_pkg::PAY_W-1:0]        p_pay, n_pay;
      logic                             p_valid, p_lt, n_valid;

      if (g == 0) begin : g_first
         assign p_key = op_key_ff;
         assign p_pay = op_payload_ff;
         assign p_valid = 1'b1;
         assign p_lt = 1'b0;
      end else begin : g_mid
         assign p_key = key_arr[g-1];
         assign p_pay = payload_arr[g-1];
         assign p_valid = valid_vec[g-1];
         assign p_lt = lt_vec[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign n_key = '0;
         assign n_pay = '0;
         assign n_valid = 1'b0;
      end else begin : g_body
         assign n_key = key_arr[g+1];
         assign n_pay = payload_arr[g+1];
         assign n_valid = valid_vec[g+1];
      end

      skt_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .new_key      (op_key_ff),
         .new_payload  (op_payload_ff),
         .prev_key     (p_key),
         .prev_payload (p_pay),
         .prev_valid   (p_valid),
         .prev_lt      (p_lt),
         .next_key     (n_key),
         .next_payload (n_pay),
         .next_valid   (n_valid),
         .key          (key_arr[g]),
         .payload      (payload_arr[g]),
         .valid        (valid_vec[g]),
         .lt           (lt_vec[g]),
         .eq           (eq_vec[g]),
         .hit_payload  (hit_arr[g])
      );
   end

   a_valid_packed: assert property (@(posedge clock) disable iff (reset)
      $onehot({1'b0, valid_vec} + {{DEPTH{1'b0}}, 1'b1}))
      else $error("occupied cells are not packed at the low end");

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(eq_vec))
      else $error("more than one cell matches the key");

   a_no_take_in_cmp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skt_pkg::S_CMP) |-> !req_chan.ready)
      else $error("request taken during compare cycle");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.ins |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
      else $error("insert did not add exactly one record");

   a_delete_shrinks: assert property (@(posedge clock) disable iff (reset)
      ctrl.del |=> $countones(valid_vec) + 1 == $past($countones(valid_vec)))
      else $error("delete did not remove exactly one record");

endmodule

[dv/sorted_key_table_test.sv]
module sorted_key_table_test;

   localparam int TABLE_DEPTH = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1530;
   localparam logic [skt_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      logic [skt_pkg::FUNC_W-1:0]        func;
      logic signed [skt_pkg::KEY_W-1:0]  key;
      logic [skt_pkg::PAY_W-1:0]         payload;
   } table_req_type;

   typedef struct {
      skt_pkg::status_type               status;
      logic [skt_pkg::PAY_W-1:0]         found_payload;
   } table_rsp_type;

   logic clock = 1'b0;
   logic reset;

   skt_req_if req_bus ();
   skt_rsp_if rsp_bus ();

   sorted_key_table #(
      .DEPTH(TABLE_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   table_req_type pending_reqs[$];
   table_rsp_type expected_rsps[$];
   logic signed [skt_pkg::KEY_W-1:0] live_keys[$];

   logic signed [skt_pkg::KEY_W-1:0] table_keys[TABLE_DEPTH];
   logic [skt_pkg::PAY_W-1:0]        table_payloads[TABLE_DEPTH];
   int table_count = 0;

   int cycle_count = 0;
   int error_count = 0;
   int rsp_seen = 0;
   int send_gap = 0;
   int stall_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   wire quiet = (cycle_count % 2048) >= 1536;

   // table shadow: apply one transaction and queue its response
   function automatic void predict_table(input table_req_type r);
      int slot;
      bit hit;
      table_rsp_type e;
      slot = 0;
      while (slot < table_count && table_keys[slot] < r.key)
         slot++;
      hit = slot < table_count && table_keys[slot] == r.key;
      e.status = skt_pkg::STATUS_NOTFOUND;
      e.found_payload = '0;
      case (r.func)
         skt_pkg::FUNC_INSERT: begin
            if (hit) begin
               e.status = skt_pkg::STATUS_DUP;
            end else if (table_count == TABLE_DEPTH) begin
               e.status = skt_pkg::STATUS_FULL;
            end else begin
               for (int i = table_count; i > slot; i--) begin
                  table_keys[i] = table_keys[i-1];
                  table_payloads[i] = table_payloads[i-1];
               end
               table_keys[slot] = r.key;
               table_payloads[slot] = r.payload;
               table_count++;
               e.status = skt_pkg::STATUS_OK;
            end
         end
         skt_pkg::FUNC_FIND: begin
            if (hit) begin
               e.status = skt_pkg::STATUS_OK;
               e.found_payload = table_payloads[slot];
            end
         end
         skt_pkg::FUNC_DELETE: begin
            if (hit) begin
               for (int i = slot; i + 1 < table_count; i++) begin
                  table_keys[i] = table_keys[i+1];
                  table_payloads[i] = table_payloads[i+1];
               end
               table_count--;
               e.status = skt_pkg::STATUS_OK;
            end
         end
         default: ;
      endcase
      expected_rsps.push_back(e);
   endfunction

   function automatic int live_slot(input logic signed [skt_pkg::KEY_W-1:0] k);
      for (int i = 0; i < live_keys.size(); i++)
         if (live_keys[i] == k)
            return i;
      return -1;
   endfunction

   function automatic void queue_request(input logic [skt_pkg::FUNC_W-1:0] f,
                                         input logic signed [skt_pkg::KEY_W-1:0] k,
                                         input logic [skt_pkg::PAY_W-1:0] p);
      table_req_type r;
      int idx;
      r.func = f;
      r.key = k;
      r.payload = p;
      pending_reqs.push_back(r);
      idx = live_slot(k);
      if (f == skt_pkg::FUNC_INSERT && idx < 0 && live_keys.size() < TABLE_DEPTH)
         live_keys.push_back(k);
      else if (f == skt_pkg::FUNC_DELETE && idx >= 0)
         live_keys.delete(idx);
   endfunction

   function automatic logic signed [skt_pkg::KEY_W-1:0] pick_key(input int hit_pct);
      int r;
      r = $urandom_range(99);
      if (live_keys.size() != 0 && r < hit_pct)
         return live_keys[$urandom_range(live_keys.size() - 1)];
      r = $urandom_range(99);
      if (r < 15) begin
         case ($urandom_range(4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return 32'h0000_0001;
         endcase
      end
      if (r < 60)
         return $signed($urandom_range(63)) - 32;
      return $urandom;
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(99);
      if (r < 55)
         return 0;
      if (r < 94)
         return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL sorted_key_table");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_table(pending_reqs[0]);
            pending_reqs.pop_front();
            send_gap = pick_gap();
         end
         if (send_gap != 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_bus.valid <= 1'b1;
            req_bus.func <= pending_reqs[0].func;
            req_bus.key <= pending_reqs[0].key;
            req_bus.payload <= pending_reqs[0].payload;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // long hold-off on the response side so the table backs up its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && rsp_seen == 400) begin
         hold_left <= 300;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      table_rsp_type e;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_seen <= rsp_seen + 1;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response status %0d payload %h", $time,
                        rsp_bus.status, rsp_bus.found_payload);
               error_count++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_bus.status !== e.status ||
                   rsp_bus.found_payload !== e.found_payload) begin
                  $display("%0t: expected status %0d payload %h, got status %0d payload %h",
                           $time, e.status, e.found_payload, rsp_bus.status,
                           rsp_bus.found_payload);
                  error_count++;
               end
            end
            stall_left = pick_gap();
         end
         if (hold_left != 0 || stall_left != 0) begin
            if (stall_left != 0)
               stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      int made;
      int kind;
      int phase_len;
      int r;
      logic [skt_pkg::FUNC_W-1:0] f;

      reset = 1'b1;

      queue_request(skt_pkg::FUNC_FIND, 32'sd5, 32'h0);
      queue_request(skt_pkg::FUNC_DELETE, 32'sd5, 32'h0);
      queue_request(skt_pkg::FUNC_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
      queue_request(skt_pkg::FUNC_INSERT, 32'h8000_0000, 32'h0000_0000);
      queue_request(skt_pkg::FUNC_INSERT, 32'h0000_0000, 32'h1234_5678);
      queue_request(skt_pkg::FUNC_INSERT, 32'hffff_ffff, 32'ha5a5_a5a5);
      queue_request(skt_pkg::FUNC_INSERT, 32'h8000_0000, 32'hdead_beef);
      queue_request(skt_pkg::FUNC_FIND, 32'h8000_0000, 32'hffff_ffff);
      queue_request(skt_pkg::FUNC_FIND, 32'h7fff_ffff, 32'h0);
      queue_request(skt_pkg::FUNC_FIND, 32'hffff_ffff, 32'h0);
      queue_request(skt_pkg::FUNC_FIND, 32'sd7, 32'h0);
      queue_request(FUNC_UNUSED, 32'h0000_0000, 32'hffff_ffff);
      queue_request(skt_pkg::FUNC_DELETE, 32'h0000_0000, 32'h0);
      queue_request(skt_pkg::FUNC_DELETE, 32'h0000_0000, 32'h0);
      queue_request(skt_pkg::FUNC_FIND, 32'h0000_0000, 32'h0);
      queue_request(skt_pkg::FUNC_INSERT, 32'sd1, 32'h5a5a_5a5a);
      queue_request(skt_pkg::FUNC_DELETE, 32'h7fff_ffff, 32'h0);
      queue_request(skt_pkg::FUNC_DELETE, 32'h8000_0000, 32'h0);
      queue_request(skt_pkg::FUNC_DELETE, 32'hffff_ffff, 32'h0);
      queue_request(skt_pkg::FUNC_DELETE, 32'sd1, 32'h0);

      // phases that fill, drain or churn the table
      made = 0;
      while (made < RANDOM_ITEMS) begin
         kind = $urandom_range(2);
         phase_len = $urandom_range(80, 20);
         for (int n = 0; n < phase_len && made < RANDOM_ITEMS; n++) begin
            r = $urandom_range(99);
            if (r < 3)
               f = FUNC_UNUSED;
            else if (kind == 0)
               f = r < 70 ? skt_pkg::FUNC_INSERT :
                   (r < 88 ? skt_pkg::FUNC_FIND : skt_pkg::FUNC_DELETE);
            else if (kind == 1)
               f = r < 60 ? skt_pkg::FUNC_DELETE :
                   (r < 80 ? skt_pkg::FUNC_INSERT : skt_pkg::FUNC_FIND);
            else
               f = r < 35 ? skt_pkg::FUNC_INSERT :
                   (r < 68 ? skt_pkg::FUNC_FIND : skt_pkg::FUNC_DELETE);
            queue_request(f, pick_key(f == skt_pkg::FUNC_INSERT ? 20 : 70), $urandom);
            made++;
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_bus.valid)
         @(posedge clock);
      while (expected_rsps.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (error_count == 0)
         $display("PASS sorted_key_table");
      else
         $display("FAIL sorted_key_table");
      $finish;
   end

endmodule
